// ===== rtl/core/idw_pkg.sv =====
// Shared types and constants for the IDW point interpolator.
package idw_pkg;

  // Input item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_WEIGHTED = 2'd0;
  localparam logic [1:0] ST_HIT      = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // Register indexes
  localparam int REG_OMEGA_SCALE = 0;
  localparam int REG_POINT_COUNT = 1;

  localparam logic [31:0] OMEGA_SCALE_RST = 32'd411775;

  // Table entry layout: x, y, z, cells, thickness
  localparam int ENTRY_W = 144;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // table read issued
    S_DX,      // square x difference
    S_DY,
    S_DZ,
    S_OMEGA,   // cells * scale
    S_CHECK,   // hit test, start reciprocal
    S_RECIP,   // 64-step reciprocal
    S_MULO,    // w * omega, low/high halves
    S_MULT,    // w * thickness
    S_NEXT,
    S_DIVO,    // 128-step division for omega
    S_DIVT,    // 128-step division for thickness
    S_OUT
  } state_t;

  // Divider control
  typedef struct packed {
    logic start;
    logic wide;   // 1: 128-bit dividend, else 64
  } div_ctl_t;

endpackage

// ===== rtl/core/idw_ram.sv =====
// Generic single-port RAM with registered read.
module idw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/idw_div.sv =====
// Restoring divider, one quotient bit a cycle, 64- or 128-bit dividend, 128-bit divisor.
module idw_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  idw_pkg::div_ctl_t    ctl,
  input  logic [127:0]         num,
  input  logic [127:0]         den,
  output logic                 done,
  output logic [127:0]         quo
);
  import idw_pkg::*;

  logic [127:0] rem_r, rem_nxt;
  logic [127:0] num_r, num_nxt;
  logic [127:0] quo_r, quo_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [128:0] trial;
  logic [127:0] shifted;

  // One step: shift in next dividend bit, compare, subtract
  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[126:0], num_r[127]};
    trial    = {1'b0, shifted} - {1'b0, den};
    if (ctl.start) begin
      rem_nxt  = '0;
      num_nxt  = ctl.wide ? num : {num[63:0], 64'd0};
      quo_nxt  = '0;
      cnt_nxt  = ctl.wide ? 8'd128 : 8'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[126:0], 1'b0};
      // rem_r[127] set means shifted exceeds any divisor below 2^128
      if (rem_r[127] || !trial[128]) begin
        rem_nxt = trial[127:0];
        quo_nxt = {quo_r[126:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[126:0], 1'b0};
      end
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign done = busy_r && (cnt_r == 8'd1);
  assign quo  = quo_nxt;
endmodule

// ===== rtl/core/idw_point_interpolator_core.sv =====
// Top level of the inverse-distance-weighted point interpolator.
// A load item writes one control table entry (indexes at or above MAX_POINTS
// are dropped) and leaves the block idle, so it stays ready for the next item.
// A query walks entries 0..n-1 in index order; each entry's time is set by the
// 64-step reciprocal of its squared distance in the shared bit-serial divider,
// and the walk ends with two 128-step divisions for omega and thickness. An
// exact hit ends the walk early and an empty table answers straight from idle.
// One item is in flight at a time; a result waiting in the output register
// holds off the next item until it is taken.
module idw_point_interpolator_core #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_entry_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [15:0] in_cell_count,
  input  logic [31:0] in_wall_thickness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_local_omega,
  output logic [31:0] out_local_thickness,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import idw_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Configuration registers
  logic [31:0] omega_scale_r;
  logic [4:0]  point_count_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_scale_r <= OMEGA_SCALE_RST;
      point_count_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        1'(REG_OMEGA_SCALE): omega_scale_r <= cfg_pwdata;
        1'(REG_POINT_COUNT): point_count_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      1'(REG_POINT_COUNT): cfg_prdata = {27'd0, point_count_r};
      default:             cfg_prdata = omega_scale_r;
    endcase
  end

  // Sequencer state
  state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_eff;
  logic signed [31:0] qx_r, qy_r, qz_r;
  logic [63:0]  d2_r, d2_nxt;
  logic [31:0]  om_r, om_nxt;
  logic [63:0]  w_r, w_nxt;
  logic [127:0] wsum_r, wsum_nxt, osum_r, osum_nxt, tsum_r, tsum_nxt;
  logic [31:0]  res_om_r, res_om_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_om_r, out_om_nxt, out_th_r, out_th_nxt;
  logic [1:0]   out_st_r, out_st_nxt;
  logic         accept;

  assign n_eff = (int'(point_count_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count_r);
  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !(out_valid_r && !out_ready);

  // Control table
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [31:0] ex, ey, ez, eth;
  logic [15:0] ecells;

  assign ram_we = accept && (in_opcode == OP_LOAD) && (int'(in_entry_index) < MAX_POINTS);
  assign ram_addr = (state_r == S_IDLE) ? AW'(in_entry_index) : idx_r[AW-1:0];
  assign ram_wdata = {in_pos_x, in_pos_y, in_pos_z, in_cell_count, in_wall_thickness};
  assign {ex, ey, ez, ecells, eth} = ram_rdata;

  idw_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Shared 32x32 multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = 64'(ma) * 64'(mb);

  // Absolute differences
  logic [32:0] dd;
  logic [31:0] dabs;
  logic signed [31:0] qsel, esel;

  // Divider
  div_ctl_t     dctl;
  logic [127:0] dnum, dden, dquo;
  logic         ddone;
  logic         sub_r, sub_nxt;  // phase within multiply states and thickness division

  idw_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  logic [64:0] dsum;
  logic [31:0] sat_q;
  assign sat_q = (dquo[127:32] != '0) ? 32'hFFFF_FFFF : dquo[31:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    d2_nxt    = d2_r;
    om_nxt    = om_r;
    w_nxt     = w_r;
    wsum_nxt  = wsum_r;
    osum_nxt  = osum_r;
    tsum_nxt  = tsum_r;
    res_om_nxt = res_om_r;
    sub_nxt   = sub_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_om_nxt = out_om_r;
    out_th_nxt = out_th_r;
    out_st_nxt = out_st_r;
    dctl      = '0;
    dnum      = '0;
    dden      = '0;
    qsel      = qx_r;
    esel      = ex;
    ma        = '0;
    mb        = '0;
    dsum      = '0;
    case (state_r)
      S_DY: begin qsel = qy_r; esel = ey; end
      S_DZ: begin qsel = qz_r; esel = ez; end
      default: ;
    endcase
    dd   = {qsel[31], qsel} - {esel[31], esel};
    dabs = dd[32] ? 32'(-dd) : dd[31:0];

    case (state_r)
      S_IDLE: begin
        if (accept && in_opcode == OP_QUERY) begin
          idx_nxt  = '0;
          wsum_nxt = '0;
          osum_nxt = '0;
          tsum_nxt = '0;
          if (n_eff == '0) begin
            out_valid_nxt = 1'b1;
            out_om_nxt = '0;
            out_th_nxt = '0;
            out_st_nxt = ST_EMPTY;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        d2_nxt = '0;
        state_nxt = S_DX;
      end
      S_DX, S_DY, S_DZ: begin
        ma = dabs;
        mb = dabs;
        dsum = {1'b0, d2_r} + {1'b0, mp};
        d2_nxt = dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
        case (state_r)
          S_DX:    state_nxt = S_DY;
          S_DY:    state_nxt = S_DZ;
          default: state_nxt = S_OMEGA;
        endcase
      end
      S_OMEGA: begin
        ma = {16'd0, ecells};
        mb = omega_scale_r;
        om_nxt = (mp[63:36] != '0) ? 32'hFFFF_FFFF : mp[35:4];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (d2_r == '0) begin
          out_valid_nxt = 1'b1;
          out_om_nxt = om_r;
          out_th_nxt = eth;
          out_st_nxt = ST_HIT;
          state_nxt = S_IDLE;
        end else begin
          dctl.start = 1'b1;
          dnum = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
          dden = {64'd0, d2_r};
          state_nxt = S_RECIP;
        end
      end
      S_RECIP: begin
        dden = {64'd0, d2_r};
        if (ddone) begin
          w_nxt = dquo[63:0];
          wsum_nxt = wsum_r + {64'd0, dquo[63:0]};
          sub_nxt = 1'b0;
          state_nxt = S_MULO;
        end
      end
      S_MULO, S_MULT: begin
        // two 32x32 partial products, one per cycle
        ma = sub_r ? w_r[63:32] : w_r[31:0];
        mb = (state_r == S_MULO) ? om_r : eth;
        if (state_r == S_MULO) begin
          osum_nxt = osum_r + (sub_r ? {32'd0, mp, 32'd0} : {64'd0, mp});
        end else begin
          tsum_nxt = tsum_r + (sub_r ? {32'd0, mp, 32'd0} : {64'd0, mp});
        end
        sub_nxt = !sub_r;
        if (sub_r) begin
          state_nxt = (state_r == S_MULO) ? S_MULT : S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx_r + CW'(1) >= n_eff) begin
          dctl.start = 1'b1;
          dctl.wide  = 1'b1;
          dnum = osum_r;
          dden = wsum_r;
          state_nxt = S_DIVO;
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      S_DIVO: begin
        dden = wsum_r;
        if (ddone) begin
          res_om_nxt = sat_q;
          state_nxt = S_DIVT;
        end
      end
      S_DIVT: begin
        // start thickness division once, then wait
        dden = wsum_r;
        if (!sub_r) begin
          dctl.start = 1'b1;
          dctl.wide  = 1'b1;
          dnum = tsum_r;
          sub_nxt = 1'b1;
        end else if (ddone) begin
          sub_nxt = 1'b0;
          out_th_nxt = sat_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_om_nxt = res_om_r;
          out_st_nxt = ST_WEIGHTED;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Weighted results wait for a free output; a stalled hit overwrites it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (state_r == S_CHECK && d2_r == '0 && out_valid_r && !out_ready) begin
        state_r <= S_CHECK;
      end else begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
      idx_r       <= idx_nxt;
    end
    if (accept) begin
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
      qz_r <= in_pos_z;
    end
    d2_r   <= d2_nxt;
    om_r   <= om_nxt;
    w_r    <= w_nxt;
    wsum_r <= wsum_nxt;
    osum_r <= osum_nxt;
    tsum_r <= tsum_nxt;
    res_om_r <= res_om_nxt;
    out_om_r <= out_om_nxt;
    out_th_r <= out_th_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_local_omega     = out_om_r;
  assign out_local_thickness = out_th_r;
  assign out_status          = out_st_r;

  // Not ready while a query walks the table
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready during query");

  // A held result keeps its status
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");

  // Weighted walk never passes the entry count
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT) |-> (idx_r < n_eff)) else $error("index overrun");

endmodule
